FILE: rtl/sts_pkg.sv
`default_nettype none
package sts_pkg;

   localparam int MAX_TASKS    = 4;
   localparam int TASK_IDX_W   = 2;
   localparam int TASK_COUNT_W = 3;
   localparam int DELAY_W      = 16;

   typedef struct packed {
      logic               kind;
      logic               tick_elapsed;
      logic [DELAY_W-1:0] sleep_ticks;
   } req_type;

   typedef struct packed {
      logic [TASK_IDX_W-1:0] running_task;
      logic                  any_ready;
   } rsp_type;

   // request to the counter bank: one load or one walk step per cycle
   typedef struct packed {
      logic                  load;
      logic [TASK_IDX_W-1:0] load_idx;
      logic [DELAY_W-1:0]    load_val;
      logic                  walk;
      logic [TASK_IDX_W-1:0] walk_idx;
      logic                  tick;
   } bank_ctrl_type;

   typedef struct packed {
      logic now_zero;
   } bank_stat_type;

endpackage
`default_nettype wire

FILE: rtl/sts_delay_bank.sv
`default_nettype none
module sts_delay_bank import sts_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire bank_ctrl_type ctrl,
   output bank_stat_type      stat
);

   logic [DELAY_W-1:0] delay_ff [MAX_TASKS];
   logic [DELAY_W-1:0] rd_val;
   logic [DELAY_W-1:0] upd_val;

   // shared decrement and zero test, applied to one counter per cycle
   always_comb begin
      rd_val  = delay_ff[ctrl.walk_idx];
      upd_val = rd_val;
      if (ctrl.tick && (rd_val != '0)) begin
         upd_val = rd_val - DELAY_W'(1);
      end
      stat.now_zero = (upd_val == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            delay_ff[i] <= '0;
         end
      end else if (ctrl.load) begin
         delay_ff[ctrl.load_idx] <= ctrl.load_val;
      end else if (ctrl.walk) begin
         delay_ff[ctrl.walk_idx] <= upd_val;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/sleep_timer_task_scheduler.sv
// Channel   Ports                          Handshake
// request   start, busy, req_item          taken when start && !busy
// result    rsp_valid, rsp_item            one cycle, no back-pressure
// config    csr_we, csr_wdata              written when csr_we
//
// A request walks the n participating tasks (0..4) one after another, one step
// per task, over the counter bank through its single decrement unit.
// The sleep load happens on the accept edge; the result follows the last step,
// or the accept itself when n is 0. busy is low again while the result is shown,
// so the next request may enter. Synchronous reset clears all counters and the running task, task_count is 3.
`default_nettype none
module sleep_timer_task_scheduler import sts_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output      logic                    busy,
   input  wire req_type                 req_item,
   output      logic                    rsp_valid,
   output rsp_type                      rsp_item,
   input  wire logic                    csr_we,
   input  wire logic [TASK_COUNT_W-1:0] csr_wdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic                    state_ff, state_in;
   logic [TASK_COUNT_W-1:0] task_count_ff;
   logic [TASK_COUNT_W-1:0] n_act;
   logic [TASK_COUNT_W-1:0] n_ff;
   logic [TASK_IDX_W-1:0]   idx_ff;
   logic                    tick_ff;
   logic                    found_ff, found_in;
   logic [TASK_IDX_W-1:0]   cur_ff, cur_in;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_item_ff;
   logic                    accept;
   logic                    last_step;
   bank_ctrl_type           bank_ctrl;
   bank_stat_type           bank_stat;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign n_act  = (task_count_ff > TASK_COUNT_W'(MAX_TASKS)) ?
                   TASK_COUNT_W'(MAX_TASKS) : task_count_ff;
   assign last_step = ({1'b0, idx_ff} == (n_ff - TASK_COUNT_W'(1)));

   always_comb begin
      bank_ctrl.load     = accept && req_item.kind;
      bank_ctrl.load_idx = cur_ff;
      bank_ctrl.load_val = req_item.sleep_ticks;
      bank_ctrl.walk     = (state_ff == ST_WALK);
      bank_ctrl.walk_idx = idx_ff;
      bank_ctrl.tick     = tick_ff;
   end

   sts_delay_bank u_bank (
      .clock (clock),
      .reset (reset),
      .ctrl  (bank_ctrl),
      .stat  (bank_stat)
   );

   // first zero counter in walk order wins
   always_comb begin
      found_in = found_ff;
      cur_in   = cur_ff;
      if ((state_ff == ST_WALK) && bank_stat.now_zero && !found_ff) begin
         found_in = 1'b1;
         cur_in   = idx_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept && (n_act != '0)) state_in = ST_WALK;
         ST_WALK: if (last_step) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         task_count_ff <= TASK_COUNT_W'(3);
         cur_ff        <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            task_count_ff <= csr_wdata;
         end
         if (accept) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
            if (n_act == '0) begin
               rsp_valid_ff <= 1'b1;
            end
         end else if (state_ff == ST_WALK) begin
            idx_ff   <= idx_ff + TASK_IDX_W'(1);
            found_ff <= found_in;
            cur_ff   <= cur_in;
            if (last_step) begin
               rsp_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         n_ff    <= n_act;
         tick_ff <= req_item.tick_elapsed;
         rsp_item_ff.running_task <= cur_ff;
         rsp_item_ff.any_ready    <= 1'b0;
      end else if ((state_ff == ST_WALK) && last_step) begin
         rsp_item_ff.running_task <= cur_in;
         rsp_item_ff.any_ready    <= found_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_accept_leads_on: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("request accepted but neither walking nor answering");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still walking");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> ({1'b0, idx_ff} < n_ff))
      else $error("walk index beyond participating tasks");

   a_ready_picks_walked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.any_ready) |-> ({1'b0, rsp_item.running_task} < n_ff))
      else $error("ready task outside participating range");

endmodule
`default_nettype wire

FILE: tb/sts_schedule_checker.sv
`timescale 1ns / 100ps
module sts_schedule_checker import sts_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  req_type                 req_item,
   input  logic                    rsp_valid,
   input  rsp_type                 rsp_item,
   input  logic                    csr_we,
   input  logic [TASK_COUNT_W-1:0] csr_wdata,
   output int                      fail_count,
   output int                      pending
);

   logic [DELAY_W-1:0]      sleep_left [MAX_TASKS];
   logic [TASK_IDX_W-1:0]   running;
   logic [TASK_COUNT_W-1:0] task_count;
   rsp_type                 expected_picks [$];

   // Applies one request to the shadow counters and returns the pick it causes.
   function automatic rsp_type next_pick(input req_type r);
      rsp_type pick;
      int      n;
      n = (int'(task_count) > MAX_TASKS) ? MAX_TASKS : int'(task_count);
      pick.any_ready = 1'b0;
      // the load hits the running task even when it no longer takes part
      if (r.kind) begin
         sleep_left[running] = r.sleep_ticks;
      end
      if (r.tick_elapsed) begin
         for (int i = 0; i < n; i++) begin
            if (sleep_left[i] != '0) begin
               sleep_left[i] = sleep_left[i] - 1'b1;
            end
         end
      end
      for (int i = 0; i < n && !pick.any_ready; i++) begin
         if (sleep_left[i] == '0) begin
            running        = TASK_IDX_W'(i);
            pick.any_ready = 1'b1;
         end
      end
      pick.running_task = running;
      return pick;
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            sleep_left[i] = '0;
         end
         running    = '0;
         task_count = 3'd3;
         expected_picks.delete();
         pending <= 0;
      end else begin
         if (csr_we) begin
            task_count = csr_wdata;
         end
         if (start && !busy) begin
            expected_picks.push_back(next_pick(req_item));
         end
         if (rsp_valid) begin
            if (expected_picks.size() == 0) begin
               $error("unexpected result: running_task %0d any_ready %0d",
                      rsp_item.running_task, rsp_item.any_ready);
               fail_count++;
            end else begin
               want = expected_picks.pop_front();
               if (rsp_item.running_task !== want.running_task) begin
                  $error("running_task: expected %0d, got %0d",
                         want.running_task, rsp_item.running_task);
                  fail_count++;
               end
               if (rsp_item.any_ready !== want.any_ready) begin
                  $error("any_ready: expected %0d, got %0d",
                         want.any_ready, rsp_item.any_ready);
                  fail_count++;
               end
            end
         end
         pending <= expected_picks.size();
      end
   end

endmodule

FILE: tb/sleep_timer_task_scheduler_tb.sv
`timescale 1ns / 100ps
module sleep_timer_task_scheduler_tb import sts_pkg::*; ();

   localparam int PHASES    = 10;
   localparam int PHASE_LEN = 163;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   req_type                 req_item;
   logic                    rsp_valid;
   rsp_type                 rsp_item;
   logic                    csr_we;
   logic [TASK_COUNT_W-1:0] csr_wdata;
   int                      fail_count;
   int                      pending;
   int                      idle_pct;

   // task counts per random phase; 0 and values above the maximum included
   logic [TASK_COUNT_W-1:0] phase_tasks [PHASES] =
      '{3'd3, 3'd5, 3'd2, 3'd0, 3'd4, 3'd1, 3'd6, 3'd7, 3'd4, 3'd3};

   sleep_timer_task_scheduler u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   sts_schedule_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("** sleep_timer_task_scheduler: FAILED **");
      $finish;
   end

   // Mostly short sleeps so tasks keep waking and the pick moves around.
   function automatic req_type random_request();
      req_type     r;
      int unsigned sel;
      sel            = $urandom_range(0, 99);
      r.kind         = ($urandom_range(0, 99) < 55);
      r.tick_elapsed = ($urandom_range(0, 99) < 70);
      if (sel < 75) begin
         r.sleep_ticks = DELAY_W'($urandom_range(0, 6));
      end else if (sel < 92) begin
         r.sleep_ticks = DELAY_W'($urandom_range(7, 400));
      end else if (sel < 97) begin
         r.sleep_ticks = DELAY_W'($urandom);
      end else begin
         r.sleep_ticks = sel[0] ? '1 : '0;
      end
      return r;
   endfunction

   task automatic send(input req_type r);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_item <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic set_task_count(input logic [TASK_COUNT_W-1:0] v);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      idle_pct  = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default count of three tasks
      send('{kind: 1'b0, tick_elapsed: 1'b0, sleep_ticks: 16'h0000});
      send('{kind: 1'b1, tick_elapsed: 1'b0, sleep_ticks: 16'hFFFF});
      send('{kind: 1'b1, tick_elapsed: 1'b1, sleep_ticks: 16'h0001});
      send('{kind: 1'b1, tick_elapsed: 1'b0, sleep_ticks: 16'h0001});
      send('{kind: 1'b1, tick_elapsed: 1'b0, sleep_ticks: 16'h8000});
      send('{kind: 1'b1, tick_elapsed: 1'b1, sleep_ticks: 16'h0000});
      send('{kind: 1'b0, tick_elapsed: 1'b1, sleep_ticks: 16'hAAAA});
      send('{kind: 1'b1, tick_elapsed: 1'b1, sleep_ticks: 16'h5555});
      // no task takes part: load only, nothing ready
      set_task_count(3'd0);
      send('{kind: 1'b1, tick_elapsed: 1'b1, sleep_ticks: 16'h0003});
      send('{kind: 1'b0, tick_elapsed: 1'b1, sleep_ticks: 16'hFFFF});
      // count above the maximum saturates
      set_task_count(3'd7);
      send('{kind: 1'b0, tick_elapsed: 1'b1, sleep_ticks: 16'h0000});
      send('{kind: 1'b1, tick_elapsed: 1'b0, sleep_ticks: 16'h0002});
      send('{kind: 1'b0, tick_elapsed: 1'b1, sleep_ticks: 16'h0000});
      send('{kind: 1'b0, tick_elapsed: 1'b1, sleep_ticks: 16'h0000});
      // running task left outside the range
      set_task_count(3'd1);
      send('{kind: 1'b1, tick_elapsed: 1'b1, sleep_ticks: 16'h0000});
      send('{kind: 1'b1, tick_elapsed: 1'b0, sleep_ticks: 16'h0007});
      send('{kind: 1'b0, tick_elapsed: 1'b1, sleep_ticks: 16'h0000});
      set_task_count(3'd4);
      send('{kind: 1'b0, tick_elapsed: 1'b0, sleep_ticks: 16'h0000});
      send('{kind: 1'b1, tick_elapsed: 1'b1, sleep_ticks: 16'hFFFF});

      for (int p = 0; p < PHASES; p++) begin
         set_task_count(phase_tasks[p]);
         idle_pct = (p % 3 == 2 || p == PHASES - 1) ? 0 : $urandom_range(5, 40);
         repeat (PHASE_LEN) send(random_request());
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("** sleep_timer_task_scheduler: PASSED **");
      end else begin
         $display("** sleep_timer_task_scheduler: FAILED **");
      end
      $finish;
   end

endmodule
